[sv/block_completion_tracker_assert.svh]
// ----------------------------------------------------------------------------
// Block completion tracker assertion macros
// Implication checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_COMPLETION_TRACKER_ASSERT_SVH
`define BLOCK_COMPLETION_TRACKER_ASSERT_SVH

// Same-cycle implication
`define BCT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BCT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/bct_pkg.sv]
// ----------------------------------------------------------------------------
// Block completion tracker package
// Shared widths, word types, controller states and the first-zero search.
// ----------------------------------------------------------------------------
package bct_pkg;

	// Field widths
	localparam int IDX_W  = 10;
	localparam int CNT_W  = 11;
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;
	localparam int ROW_W  = IDX_W - BIT_W;
	localparam int POS_W  = BIT_W + 1;

	// Register port
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;
	localparam logic REG_BLK_COUNT = 1'b0;

	// Parameter defaults
	localparam int MAX_BLOCKS_DEF = 1024;
	localparam int RANGE_SPAN_DEF = 8;

	// Operation codes
	localparam logic OP_MARK = 1'b0;
	localparam logic OP_TEST = 1'b1;

	typedef struct packed {
		logic             op;
		logic [IDX_W-1:0] block_index;
	} item_t;

	typedef struct packed {
		logic             present;
		logic             index_error;
		logic             range_valid;
		logic [CNT_W-1:0] range_start;
		logic [CNT_W-1:0] range_end;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_RESP
	} state_t;

	// Position of the lowest zero bit at or above start; WORD_W if none
	function automatic logic [POS_W-1:0] first_zero(input logic [WORD_W-1:0] bits,
		input logic [BIT_W-1:0] start);
		logic [WORD_W-1:0] open_bits;
		logic [POS_W-1:0]  pos;
		open_bits = ~bits & ({WORD_W{1'b1}} << start);
		pos = POS_W'(WORD_W);
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (open_bits[i]) begin
				pos = POS_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

[sv/block_completion_tracker.sv]
// ----------------------------------------------------------------------------
// Block completion tracker
// Presence bitmap of received blocks with a pointer to the first missing one.
// ----------------------------------------------------------------------------
// Usage: write the block count over the APB port while the block is idle. Each
// word on the item channel (valid/ready) marks (op 0) or tests (op 1) one block
// and yields exactly one word on the result channel: the presence bit, an index
// error flag, and the next fetch range starting at the first missing block.
// An item goes through the look-up state, where the word read on acceptance
// is updated and, for a mark, written back, then the response state, which
// loads the result register; an index error goes straight to the response.
// When a mark moves the pointer, the scan state may first read further words.
// The scan covers 32 blocks per cycle, one read of the bitmap memory each. The
// next item is taken in the cycle after the previous result is loaded.
// The result register holds a finished word while the receiver stalls; the
// next item is accepted meanwhile and its result waits until the register
// empties.
// Reset clears the pointer, the block count and the per-row valid flags, so
// the whole bitmap reads as empty at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "block_completion_tracker_assert.svh"

module block_completion_tracker #(
	parameter int MAX_BLOCKS = bct_pkg::MAX_BLOCKS_DEF,
	parameter int RANGE_SPAN = bct_pkg::RANGE_SPAN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bct_pkg::PADDR_W-1:0] paddr,
	input  logic [bct_pkg::DATA_W-1:0]  pwdata,
	output logic [bct_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  bct_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output bct_pkg::result_t            result
);

	logic [bct_pkg::CNT_W-1:0] count;

	// Configuration register
	bct_cfg #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.count   (count)
	);

	// Bitmap and pointer engine
	bct_engine #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.RANGE_SPAN (RANGE_SPAN)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.count        (count),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Checks
	`BCT_ASSERT_NXT(a_busy_after_accept, item_valid && item_ready, !item_ready,
		"item accepted while previous item still in work")
	`BCT_ASSERT_IMP(a_err_not_present, result_valid && result.index_error, !result.present,
		"index error reported with presence bit set")
	`BCT_ASSERT_IMP(a_range_order, result_valid && result.range_valid,
		result.range_start <= result.range_end, "fetch range ends before it starts")
	`BCT_ASSERT_IMP(a_range_empty, result_valid && !result.range_valid,
		result.range_end == result.range_start, "invalid range with differing bounds")

endmodule

[sv/bct_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/bct_cfg.sv]
// ----------------------------------------------------------------------------
// Block completion tracker register port
// Holds the block count and presents it clipped to MAX_BLOCKS (at most 2047).
// ----------------------------------------------------------------------------
module bct_cfg #(
	parameter int MAX_BLOCKS = bct_pkg::MAX_BLOCKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bct_pkg::PADDR_W-1:0]  paddr,
	input  logic [bct_pkg::DATA_W-1:0]   pwdata,
	output logic [bct_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output logic [bct_pkg::CNT_W-1:0]    count
);

	localparam int CNT_TOP = (1 << bct_pkg::CNT_W) - 1;
	localparam int CAP = (MAX_BLOCKS > CNT_TOP) ? CNT_TOP : MAX_BLOCKS;

	logic [bct_pkg::CNT_W-1:0] blk_count_q;
	logic                      hit;

	assign hit    = (paddr[bct_pkg::PADDR_W-1] == bct_pkg::REG_BLK_COUNT);
	assign pready = 1'b1;

	// Capture the register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_count_q <= '0;
		end else if (psel && penable && pwrite && pready && hit) begin
			blk_count_q <= pwdata[bct_pkg::CNT_W-1:0];
		end
	end

	// Read back
	always_comb begin
		unique case (paddr[bct_pkg::PADDR_W-1])
			bct_pkg::REG_BLK_COUNT: prdata = bct_pkg::DATA_W'(blk_count_q);
			default:                prdata = '0;
		endcase
	end

	// Clip the count to MAX_BLOCKS and to the count width
	assign count = (blk_count_q > bct_pkg::CNT_W'(CAP)) ? bct_pkg::CNT_W'(CAP) : blk_count_q;

endmodule

[sv/bct_engine.sv]
// ----------------------------------------------------------------------------
// Block completion tracker engine
// Read-modify-write of the bitmap words and the word-wise pointer scan.
// ----------------------------------------------------------------------------
module bct_engine #(
	parameter int MAX_BLOCKS = bct_pkg::MAX_BLOCKS_DEF,
	parameter int RANGE_SPAN = bct_pkg::RANGE_SPAN_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bct_pkg::CNT_W-1:0] count,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  bct_pkg::item_t            item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output bct_pkg::result_t          result
);

	localparam int IDX_SPAN = 1 << bct_pkg::IDX_W;
	localparam int DEPTH    = (MAX_BLOCKS < IDX_SPAN) ? MAX_BLOCKS : IDX_SPAN;
	localparam int ROWS     = (DEPTH + bct_pkg::WORD_W - 1) / bct_pkg::WORD_W;
	localparam int RAW      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ROW_END  = ROWS * bct_pkg::WORD_W;

	bct_pkg::state_t                 state_q, state_d;
	logic [bct_pkg::CNT_W-1:0]       ptr_q, ptr_d;
	logic [bct_pkg::ROW_W-1:0]       rd_row_q, rd_row_d;
	logic [ROWS-1:0]                 row_vld_q;
	logic                            op_q;
	logic [bct_pkg::IDX_W-1:0]       idx_q;
	logic                            err_q;
	logic                            present_q, present_d;
	logic                            rsp_valid_q;
	bct_pkg::result_t                rsp_q;

	logic                            accept, item_err, rsp_load;
	logic                            ram_we, ram_re;
	logic [RAW-1:0]                  ram_raddr;
	logic [bct_pkg::WORD_W-1:0]      ram_rdata, rd_word, new_word, srch_word;
	logic [bct_pkg::BIT_W-1:0]       srch_start;
	logic [bct_pkg::POS_W-1:0]       pos;
	logic [bct_pkg::CNT_W-1:0]       cand, cand_clip;
	logic [bct_pkg::ROW_W-1:0]       cand_row;
	logic                            stop;
	logic                            rng_valid;
	logic [bct_pkg::CNT_W:0]         span_sum;
	logic [bct_pkg::CNT_W-1:0]       last_blk, rng_end;

	// Bitmap words, one row per WORD_W blocks
	bct_ram #(
		.WIDTH (bct_pkg::WORD_W),
		.DEPTH (ROWS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (rd_row_q[RAW-1:0]),
		.wdata (new_word),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign item_ready = (state_q == bct_pkg::ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign item_err   = ({1'b0, item.block_index} >= count);

	// A row never written reads as all zero
	assign rd_word  = row_vld_q[rd_row_q[RAW-1:0]] ? ram_rdata : '0;
	assign new_word = (op_q == bct_pkg::OP_MARK)
		? (rd_word | (bct_pkg::WORD_W'(1) << idx_q[bct_pkg::BIT_W-1:0])) : rd_word;

	// Search for the first missing block from the pointer position
	assign srch_word  = (state_q == bct_pkg::ST_LOOK) ? new_word : rd_word;
	assign srch_start = (state_q == bct_pkg::ST_LOOK) ? idx_q[bct_pkg::BIT_W-1:0]
		: ptr_q[bct_pkg::BIT_W-1:0];
	assign pos       = bct_pkg::first_zero(srch_word, srch_start);
	assign cand      = bct_pkg::CNT_W'({rd_row_q, {bct_pkg::BIT_W{1'b0}}})
		+ bct_pkg::CNT_W'(pos);
	assign cand_clip = (cand > count) ? count : cand;
	assign cand_row  = cand[bct_pkg::IDX_W-1:bct_pkg::BIT_W];
	assign stop      = !pos[bct_pkg::POS_W-1] || (cand >= count)
		|| (cand >= bct_pkg::CNT_W'(ROW_END));

	// Next fetch range from the current pointer
	assign rng_valid = (ptr_q < count);
	assign span_sum  = {1'b0, ptr_q} + (bct_pkg::CNT_W + 1)'(RANGE_SPAN);
	assign last_blk  = count - bct_pkg::CNT_W'(1);
	assign rng_end   = !rng_valid ? ptr_q
		: ((span_sum > {1'b0, last_blk}) ? last_blk : span_sum[bct_pkg::CNT_W-1:0]);

	// Sequence one item: look up, scan if the pointer moves, respond
	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		rd_row_d  = rd_row_q;
		present_d = present_q;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = item.block_index[bct_pkg::IDX_W-1:bct_pkg::BIT_W];
		rsp_load  = 1'b0;
		unique case (state_q)
			bct_pkg::ST_IDLE: begin
				if (accept) begin
					if (item_err) begin
						present_d = 1'b0;
						state_d   = bct_pkg::ST_RESP;
					end else begin
						ram_re   = 1'b1;
						rd_row_d = item.block_index[bct_pkg::IDX_W-1:bct_pkg::BIT_W];
						state_d  = bct_pkg::ST_LOOK;
					end
				end
			end
			bct_pkg::ST_LOOK: begin
				ram_we    = (op_q == bct_pkg::OP_MARK);
				present_d = new_word[idx_q[bct_pkg::BIT_W-1:0]];
				if ((op_q == bct_pkg::OP_MARK) && (ptr_q == {1'b0, idx_q})) begin
					ptr_d = cand_clip;
					if (stop) begin
						state_d = bct_pkg::ST_RESP;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = cand_row[RAW-1:0];
						rd_row_d  = cand_row;
						state_d   = bct_pkg::ST_SCAN;
					end
				end else begin
					state_d = bct_pkg::ST_RESP;
				end
			end
			bct_pkg::ST_SCAN: begin
				ptr_d = cand_clip;
				if (stop) begin
					state_d = bct_pkg::ST_RESP;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = cand_row[RAW-1:0];
					rd_row_d  = cand_row;
				end
			end
			bct_pkg::ST_RESP: begin
				if (!rsp_valid_q || result_ready) begin
					rsp_load = 1'b1;
					state_d  = bct_pkg::ST_IDLE;
				end
			end
			default: state_d = bct_pkg::ST_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bct_pkg::ST_IDLE;
			ptr_q       <= '0;
			row_vld_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			if (ram_we) begin
				row_vld_q[rd_row_q[RAW-1:0]] <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (result_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Item and result words
	always_ff @(posedge clk) begin
		rd_row_q  <= rd_row_d;
		present_q <= present_d;
		if (accept) begin
			op_q  <= item.op;
			idx_q <= item.block_index;
			err_q <= item_err;
		end
		if (rsp_load) begin
			rsp_q.present     <= present_q;
			rsp_q.index_error <= err_q;
			rsp_q.range_valid <= rng_valid;
			rsp_q.range_start <= ptr_q;
			rsp_q.range_end   <= rng_end;
		end
	end

	assign result_valid = rsp_valid_q;
	assign result       = rsp_q;

endmodule
